// ===== hw/rtl/ace_pkg.sv =====
// ace_pkg: shared types and constants of the ACE target detector.
// Used by ace_front, ace_back and ace_target_detector.
package ace_pkg;

    localparam int BANDS_DEF = 20;
    localparam int ROW_W     = 5;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int SCORE_W   = 17;
    localparam int COUNT_W   = 24;
    localparam int ENERGY_W  = 63;
    localparam int THRESH_W  = 17;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;

    localparam logic [THRESH_W-1:0] THRESH_RST = 17'd39322;
    localparam logic [SCORE_W-1:0]  SCORE_ONE  = 17'd65536;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 24'hFFFFFF;

    localparam logic REG_ENERGY = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [1:0] {
        CMD_MATRIX = 2'd0,
        CMD_PROJ   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              first;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [THRESH_W-1:0] thresh;
    } cfg_t;

    typedef enum logic [2:0] {
        TG_NUM,
        TG_DIAG,
        TG_PAIR,
        TG_QLO,
        TG_QHI,
        TG_NUMSQ,
        TG_DEN
    } tag_t;

    typedef struct packed {
        logic       valid;
        tag_t       tag;
        logic [1:0] part;
    } stage_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_QUAD,
        ST_QDRAIN,
        ST_FIN,
        ST_FMUL,
        ST_FDRAIN,
        ST_CMP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/ace_front.sv =====
// ace_front: accepts stream requests, drops ignored ones, tracks band order
// and queues the rest for ace_back. Depends on ace_pkg.
module ace_front
    import ace_pkg::*;
#(
    parameter int BANDS = BANDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row_index, col_index, data_word, zero pad
    input  logic [CMD_W-1:0]     s_tuser,   // command
    output logic                 q_valid,
    output item_t                q_item,
    input  logic                 q_pop
);

    item_t              queue_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;
    logic [ROW_W-1:0]   next_band_reg, next_band_next;
    item_t              item;
    logic               keep, push, accept, row_ok, col_ok;

    always_comb
    begin
        item.cmd   = cmd_t'(s_tuser);
        item.row   = s_tdata[4:0];
        item.col   = s_tdata[9:5];
        item.data  = s_tdata[41:10];
        item.first = (item.row == '0);
        item.last  = (int'(item.row) == BANDS - 1);
        row_ok     = (int'(item.row) < BANDS);
        col_ok     = (int'(item.col) < BANDS);
        case (item.cmd)
            CMD_MATRIX: keep = row_ok && col_ok;
            CMD_PROJ:   keep = row_ok;
            CMD_SAMPLE: keep = row_ok && (item.first || item.row == next_band_reg);
            default:    keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && keep;
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];

    always_comb
    begin
        next_band_next = next_band_reg;
        if (push && item.cmd == CMD_SAMPLE)
        begin
            next_band_next = item.last ? '0 : item.row + 1'b1;
        end
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            next_band_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            next_band_reg <= next_band_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

// ===== hw/rtl/ace_back.sv =====
// ace_back: coefficient memories, shared multiply-accumulate pipeline,
// score division and result register. Depends on ace_pkg.
module ace_back
    import ace_pkg::*;
#(
    parameter int BANDS = BANDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  item_t                q_item,
    output logic                 q_pop,
    input  cfg_t                 cfg,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // ace_score, is_target, target_count,
                                            // zero_energy, zero pad
);

    localparam int AW = $clog2(BANDS * BANDS);
    localparam int BW = $clog2(BANDS);
    localparam int TW = $clog2(BANDS + 16);

    logic [DATA_W-1:0] mat_mem  [BANDS * BANDS];
    logic [DATA_W-1:0] proj_mem [BANDS];
    logic [DATA_W-1:0] pix_mem  [BANDS];
    logic [DATA_W-1:0] mat_rd_a, mat_rd_b, proj_rd, pix_rd;
    logic [AW-1:0]     addr_a, addr_b, mat_waddr;
    logic [BW-1:0]     j_idx;

    state_t             state_reg, state_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [BW-1:0]      k_reg;
    logic               last_reg;
    logic [DATA_W-1:0]  x_reg;
    logic [63:0]        num_reg, quad_reg, row_reg, mag_reg;
    logic [127:0]       numw_reg, denw_reg, rem_reg, rem_shl;
    logic [SCORE_W-1:0] score_reg;
    logic               zero_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_hit_reg, out_zero_reg;
    logic [COUNT_W-1:0] out_count_reg;

    stage_t             iss, b_reg, c_reg, d_reg;
    logic signed [32:0] opa, opb, opa_reg, opb_reg;
    logic signed [65:0] prod_reg;
    logic [63:0]        p64;
    logic [31:0]        half_a, half_b;
    logic               busy, hit, load_out, rem_ge;

    assign busy    = b_reg.valid || c_reg.valid || d_reg.valid;
    assign j_idx   = BW'(t_reg - TW'(2));
    assign rem_shl = {rem_reg[126:0], 1'b0};
    assign rem_ge  = (rem_shl >= denw_reg);
    assign hit     = (score_reg > cfg.thresh);

    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        iss        = '{valid: 1'b0, tag: TG_NUM, part: 2'd0};
        addr_a     = AW'(int'(k_reg) * BANDS + int'(j_idx));
        addr_b     = AW'(int'(j_idx) * BANDS + int'(k_reg));
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.cmd == CMD_SAMPLE)
                    begin
                        t_next     = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                iss.valid = 1'b1;
                if (t_reg == '0)
                begin
                    iss.tag = TG_NUM;
                end
                else if (t_reg == TW'(1))
                begin
                    iss.tag = TG_DIAG;
                    addr_a  = AW'(int'(k_reg) * BANDS + int'(k_reg));
                end
                else
                begin
                    iss.tag = TG_PAIR;
                end
                t_next = t_reg + 1'b1;
                if (t_reg == TW'(k_reg) + TW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    t_next     = '0;
                    state_next = ST_QUAD;
                end
            end
            ST_QUAD:
            begin
                iss.valid = 1'b1;
                iss.tag   = (t_reg == '0) ? TG_QLO : TG_QHI;
                t_next    = t_reg + 1'b1;
                if (t_reg != '0)
                begin
                    state_next = ST_QDRAIN;
                end
            end
            ST_QDRAIN:
            begin
                if (!busy)
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN:
            begin
                t_next = '0;
                if (quad_reg[63] || quad_reg == '0 || cfg.energy == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL:
            begin
                iss.valid = 1'b1;
                iss.tag   = t_reg[2] ? TG_DEN : TG_NUMSQ;
                iss.part  = t_reg[1:0];
                t_next    = t_reg + 1'b1;
                if (t_reg[2:0] == 3'd7)
                begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN:
            begin
                if (!busy)
                begin
                    t_next     = '0;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = (numw_reg >= denw_reg) ? ST_OUT : ST_DIV;
            end
            ST_DIV:
            begin
                t_next = t_reg + 1'b1;
                if (t_reg == TW'(15))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operand select for the shared multiplier
    always_comb
    begin
        half_a = 32'd0;
        half_b = 32'd0;
        if (b_reg.tag == TG_DEN)
        begin
            half_a = b_reg.part[0] ? {1'b0, cfg.energy[62:32]} : cfg.energy[31:0];
            half_b = b_reg.part[1] ? quad_reg[63:32] : quad_reg[31:0];
        end
        else
        begin
            half_a = b_reg.part[0] ? mag_reg[63:32] : mag_reg[31:0];
            half_b = b_reg.part[1] ? mag_reg[63:32] : mag_reg[31:0];
        end
        opb = {x_reg[31], x_reg};
        case (b_reg.tag)
            TG_NUM:   opa = {proj_rd[31], proj_rd};
            TG_DIAG:  opa = {mat_rd_a[31], mat_rd_a};
            TG_PAIR:
            begin
                opa = $signed({mat_rd_a[31], mat_rd_a}) + $signed({mat_rd_b[31], mat_rd_b});
                opb = {pix_rd[31], pix_rd};
            end
            TG_QLO:   opa = {1'b0, row_reg[31:0]};
            TG_QHI:   opa = {1'b0, row_reg[63:32]};
            default:
            begin
                opa = {1'b0, half_a};
                opb = {1'b0, half_b};
            end
        endcase
    end

    assign p64 = prod_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            t_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            num_reg       <= '0;
            quad_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            b_reg     <= iss;
            c_reg     <= b_reg;
            d_reg     <= c_reg;
            if (q_pop && q_item.cmd == CMD_SAMPLE && q_item.first)
            begin
                num_reg  <= '0;
                quad_reg <= '0;
            end
            if (d_reg.valid)
            begin
                case (d_reg.tag)
                    TG_NUM:  num_reg  <= num_reg + p64;
                    TG_QLO:  quad_reg <= quad_reg + p64;
                    TG_QHI:  quad_reg <= quad_reg + {p64[31:0], 32'd0};
                    default: ;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (hit && count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg  <= opa;
        opb_reg  <= opb;
        prod_reg <= opa_reg * opb_reg;
        if (q_pop)
        begin
            k_reg    <= BW'(q_item.row);
            x_reg    <= q_item.data;
            last_reg <= q_item.last;
            row_reg  <= '0;
        end
        if (d_reg.valid)
        begin
            case (d_reg.tag)
                TG_DIAG, TG_PAIR: row_reg <= row_reg + p64;
                TG_NUMSQ:
                begin
                    case (d_reg.part)
                        2'd0:    numw_reg <= numw_reg + {64'd0, p64};
                        2'd3:    numw_reg <= numw_reg + {p64, 64'd0};
                        default: numw_reg <= numw_reg + {32'd0, p64, 32'd0};
                    endcase
                end
                TG_DEN:
                begin
                    case (d_reg.part)
                        2'd0:    denw_reg <= denw_reg + {64'd0, p64};
                        2'd3:    denw_reg <= denw_reg + {p64, 64'd0};
                        default: denw_reg <= denw_reg + {32'd0, p64, 32'd0};
                    endcase
                end
                default: ;
            endcase
        end
        case (state_reg)
            ST_FIN:
            begin
                score_reg <= '0;
                zero_reg  <= !quad_reg[63] && (quad_reg == '0 || cfg.energy == '0);
                mag_reg   <= num_reg[63] ? (64'd0 - num_reg) : num_reg;
                numw_reg  <= '0;
                denw_reg  <= '0;
            end
            ST_CMP:
            begin
                rem_reg   <= numw_reg;
                score_reg <= (numw_reg >= denw_reg) ? SCORE_ONE : '0;
            end
            ST_DIV:
            begin
                rem_reg   <= rem_ge ? (rem_shl - denw_reg) : rem_shl;
                score_reg <= {score_reg[SCORE_W-2:0], rem_ge};
            end
            default: ;
        endcase
        if (load_out)
        begin
            out_score_reg <= score_reg;
            out_hit_reg   <= hit;
            out_zero_reg  <= zero_reg;
            out_count_reg <= (hit && count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
        end
    end

    // memories
    assign mat_waddr = AW'(int'(q_item.row) * BANDS + int'(q_item.col));

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.cmd == CMD_MATRIX)
        begin
            mat_mem[mat_waddr] <= q_item.data;
        end
        if (q_pop && q_item.cmd == CMD_PROJ)
        begin
            proj_mem[BW'(q_item.row)] <= q_item.data;
        end
        if (q_pop && q_item.cmd == CMD_SAMPLE)
        begin
            pix_mem[BW'(q_item.row)] <= q_item.data;
        end
        mat_rd_a <= mat_mem[addr_a];
        mat_rd_b <= mat_mem[addr_b];
        proj_rd  <= proj_mem[k_reg];
        pix_rd   <= pix_mem[j_idx];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_zero_reg, out_count_reg, out_hit_reg, out_score_reg};

endmodule

// ===== hw/rtl/ace_target_detector.sv =====
// ace_target_detector: top level, config registers, front queue and back end.
// Depends on ace_pkg, ace_front, ace_back.
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tuser: command; s_tdata: row, col, data
// m        out  m_tvalid/m_tready  m_tdata: score, is_target, count, zero_energy
// cfg      in   cfg_we             cfg_index, cfg_data
//
// A load is popped and stored while the back end stays idle; a sample for band k goes
// through pop, issue of its k+2 products, a drain, two quadratic steps and a second drain.
// The last band adds 8 wide products, a drain, the compare, 16 division steps and the
// output load; only the output load when the denominator is zero or negative.
// A 4-entry queue lets requests arrive while the back end is busy.
// Reset is asynchronous and clears control state and counters.
module ace_target_detector
    import ace_pkg::*;
#(
    parameter int BANDS = BANDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // row_index[4:0], col_index[9:5],
                                            // data_word[41:10], zero pad
    input  logic [CMD_W-1:0]     s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // ace_score[16:0], is_target[17],
                                            // target_count[41:18], zero_energy[42]
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [ENERGY_W-1:0]  cfg_data
);

    logic [ENERGY_W-1:0] energy_reg;
    logic [THRESH_W-1:0] thresh_reg;
    cfg_t                cfg;
    logic                q_valid, q_pop;
    item_t               q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ENERGY)
            begin
                energy_reg <= cfg_data;
            end
            else
            begin
                thresh_reg <= cfg_data[THRESH_W-1:0];
            end
        end
    end

    assign cfg.energy = energy_reg;
    assign cfg.thresh = thresh_reg;

    ace_front #(.BANDS(BANDS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ace_back #(.BANDS(BANDS)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[42] |-> m_tdata[16:0] == '0)
        else $error("zero_energy with nonzero score");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[41:18] != '0)
        else $error("detection with zero count");

    a_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:0] <= SCORE_ONE)
        else $error("score above one");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

endmodule

// ===== tb/ace_target_detector_tb.sv =====
// ace_target_detector_tb: self-checking testbench for the ACE target detector.
// Drives loads and pixel bands on the s stream, predicts each score in-bench
// and checks every m result. Depends on ace_pkg and ace_target_detector.
module ace_target_detector_tb;
    import ace_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB        = 20;
    localparam int MAX_CYC   = 1500000;
    localparam int QUIET_CYC = 200;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               hit;
        logic [COUNT_W-1:0] count;
        logic               zero;
    } score_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [ENERGY_W-1:0]  cfg_data = '0;

    // predictor state
    logic [31:0]          rinv [NB*NB];
    logic [31:0]          sproj [NB];
    logic [31:0]          pix [NB];
    logic [63:0]          num_acc, quad_acc;
    logic [COUNT_W-1:0]   hits;
    int                   next_band;
    logic [ENERGY_W-1:0]  energy;
    logic [THRESH_W-1:0]  thresh;

    score_t               pending_scores[$];
    int                   send_idle_pct, recv_idle_pct;
    int                   errors, results_seen, requests_sent, cycles;

    ace_target_detector uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[ace_target_detector] ERROR");
            $finish;
        end
    end

    function automatic logic [63:0] sx(input logic [31:0] w);
        return {{32{w[31]}}, w};
    endfunction

    function automatic void predict_request(input logic [1:0] c, input logic [4:0] r,
                                            input logic [4:0] cl, input logic [31:0] d);
        logic [63:0]  x, rowsum, pair, mag;
        logic [127:0] nsq, dsq;
        logic [143:0] q;
        score_t       e;
        if (c == CMD_MATRIX)
        begin
            if (r < NB && cl < NB)
                rinv[r*NB+cl] = d;
            return;
        end
        if (c == CMD_PROJ)
        begin
            if (r < NB)
                sproj[r] = d;
            return;
        end
        if (c != CMD_SAMPLE || r >= NB)
            return;
        if (r == 0)
        begin
            num_acc = '0;
            quad_acc = '0;
            next_band = 0;
        end
        else if (r != next_band)
            return;
        x = sx(d);
        pix[r] = d;
        num_acc += sx(sproj[r]) * x;
        rowsum = sx(rinv[r*NB+r]) * x;
        for (int j = 0; j < r; j++)
        begin
            pair = sx(rinv[r*NB+j]) + sx(rinv[j*NB+r]);
            rowsum += pair * sx(pix[j]);
        end
        quad_acc += rowsum * x;
        if (r + 1 < NB)
        begin
            next_band = r + 1;
            return;
        end
        next_band = 0;
        e = '0;
        if (!quad_acc[63])
        begin
            if (quad_acc == 0 || energy == 0)
                e.zero = 1'b1;
            else
            begin
                mag = num_acc[63] ? -num_acc : num_acc;
                nsq = {64'b0, mag} * {64'b0, mag};
                dsq = {65'b0, energy} * {64'b0, quad_acc};
                if (nsq >= dsq)
                    e.score = SCORE_ONE;
                else
                begin
                    q = {nsq, 16'b0} / {16'b0, dsq};
                    e.score = q[SCORE_W-1:0];
                end
            end
        end
        if (e.score > thresh)
        begin
            e.hit = 1'b1;
            if (hits != COUNT_MAX)
                hits++;
        end
        e.count = hits;
        num_acc = '0;
        quad_acc = '0;
        pending_scores.push_back(e);
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        score_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_scores.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end
            else
            begin
                e = pending_scores.pop_front();
                if (m_tdata[16:0] !== e.score)
                begin
                    $error("ace_score exp %0d got %0d", e.score, m_tdata[16:0]);
                    errors++;
                end
                if (m_tdata[17] !== e.hit)
                begin
                    $error("is_target exp %0d got %0d", e.hit, m_tdata[17]);
                    errors++;
                end
                if (m_tdata[41:18] !== e.count)
                begin
                    $error("target_count exp %0d got %0d", e.count, m_tdata[41:18]);
                    errors++;
                end
                if (m_tdata[42] !== e.zero)
                begin
                    $error("zero_energy exp %0d got %0d", e.zero, m_tdata[42]);
                    errors++;
                end
            end
        end
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_req(input logic [1:0] c, input logic [4:0] r,
                            input logic [4:0] cl, input logic [31:0] d);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {6'b0, d, cl, r};
        do @(posedge clk); while (!s_tready);
        predict_request(c, r, cl, d);
        requests_sent++;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ENERGY_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ENERGY)
            energy = v;
        else
            thresh = v[THRESH_W-1:0];
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        int m;
        m = $urandom_range(99);
        if (m < 70)
            return 32'($signed($urandom_range(65535)) - 32768);
        if (m < 90)
            return 32'($signed($urandom_range(2097151)) - 1048576);
        return $urandom;
    endfunction

    task automatic send_pixel(input logic [31:0] fixed, input bit use_fixed);
        for (int b = 0; b < NB; b++)
            send_req(CMD_SAMPLE, 5'(b), 5'($urandom), use_fixed ? fixed : rand_sample());
    endtask

    task automatic test_load_tables();
        for (int r = 0; r < NB; r++)
        begin
            for (int c = 0; c < NB; c++)
                send_req(CMD_MATRIX, 5'(r), 5'(c), (r == c) ?
                         32'(24'hFFFFFF + $urandom_range(16777216)) :
                         32'($signed($urandom_range(2097151)) - 1048576));
            send_req(CMD_PROJ, 5'(r), 5'($urandom), 32'($signed($urandom_range(33554431))
                     - 16777216));
        end
    endtask

    task automatic test_special_cases();
        logic [31:0] keep;
        // energy zero, then all-zero pixel
        send_pixel(32'd1000, 1);
        wait_quiet();
        write_reg(REG_ENERGY, 63'd1);
        send_pixel(32'd0, 1);
        // tiny energy saturates the score; extreme samples wrap accumulators
        send_pixel(32'h7FFF_FFFF, 1);
        send_pixel(32'h8000_0000, 1);
        // negative quadratic form
        keep = rinv[0];
        send_req(CMD_MATRIX, 5'd0, 5'd0, 32'h8000_0000);
        send_req(CMD_SAMPLE, 5'd0, 5'd0, 32'd1000);
        for (int b = 1; b < NB; b++)
            send_req(CMD_SAMPLE, 5'(b), 5'd0, 32'd0);
        send_req(CMD_MATRIX, 5'd0, 5'd0, keep);
        // ignored items: bad indexes, unused command, out-of-order band
        send_req(CMD_MATRIX, 5'd31, 5'd3, $urandom);
        send_req(CMD_MATRIX, 5'd3, 5'd20, $urandom);
        send_req(CMD_PROJ, 5'd20, 5'd0, $urandom);
        send_req(CMD_UNUSED, 5'd0, 5'd0, $urandom);
        send_req(CMD_SAMPLE, 5'd25, 5'd0, $urandom);
        send_req(CMD_SAMPLE, 5'd0, 5'd0, 32'd7);
        send_req(CMD_SAMPLE, 5'd5, 5'd0, 32'd7);
        // band zero restarts; load mid-pixel
        send_req(CMD_SAMPLE, 5'd0, 5'd0, 32'd9);
        send_req(CMD_SAMPLE, 5'd1, 5'd0, 32'd9);
        send_req(CMD_PROJ, 5'd5, 5'd0, 32'h0100_0000);
        send_pixel(32'd0, 0);
        wait_quiet();
        write_reg(REG_THRESH, 17'd65536);
        write_reg(REG_ENERGY, 63'h7FFF_FFFF_FFFF_FFFF);
        send_pixel(32'd0, 0);
        wait_quiet();
        write_reg(REG_THRESH, 17'd0);
        write_reg(REG_ENERGY, 63'd1 << 30);
        send_pixel(32'd0, 0);
        wait_quiet();
    endtask

    task automatic test_random_pixels(input int npix, input int sidle, input int ridle);
        int m;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        write_reg(REG_ENERGY, 63'($urandom_range(32'h4000_0000, 32'h0100_0000)));
        write_reg(REG_THRESH, 17'($urandom_range(65536)));
        for (int p = 0; p < npix; p++)
        begin
            m = $urandom_range(99);
            if (m < 75)
                send_pixel(32'd0, 0);
            else if (m < 85)
            begin
                // abandoned or skipping pixel
                for (int b = 0; b < $urandom_range(NB - 1, 1); b++)
                    send_req(CMD_SAMPLE, 5'(b), 5'($urandom), rand_sample());
                send_req(CMD_SAMPLE, 5'($urandom_range(NB - 1, 1)), 5'd0, rand_sample());
            end
            else
            begin
                repeat ($urandom_range(6, 1))
                begin
                    m = $urandom_range(2);
                    if (m == 0)
                        send_req(CMD_PROJ, 5'($urandom_range(NB - 1)), 5'($urandom),
                                 32'($signed($urandom_range(33554431)) - 16777216));
                    else if (m == 1)
                        send_req(CMD_MATRIX, 5'($urandom), 5'($urandom), $urandom);
                    else
                        send_req(2'($urandom), 5'($urandom), 5'($urandom), $urandom);
                end
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        errors = 0;
        results_seen = 0;
        requests_sent = 0;
        cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 69;
        num_acc = '0;
        quad_acc = '0;
        hits = '0;
        next_band = 0;
        energy = '0;
        thresh = THRESH_RST;
        foreach (pix[i])
            pix[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_tables();
        test_special_cases();
        test_random_pixels(10, 10, 69);
        test_random_pixels(10, 69, 10);
        test_random_pixels(10, 0, 0);
        $display("%0d requests sent, %0d scores checked, %0d detections counted",
                 requests_sent, results_seen, hits);
        $display("covered loads, ignored items, band restarts, zero and negative forms");
        if (errors == 0)
            $display("[ace_target_detector] OK");
        else
            $display("[ace_target_detector] ERROR");
        $finish;
    end
endmodule

// ===== ace_target_detector.f =====
hw/rtl/ace_pkg.sv
hw/rtl/ace_front.sv
hw/rtl/ace_back.sv
hw/rtl/ace_target_detector.sv
tb/ace_target_detector_tb.sv
